### design/sipf_pkg.sv
`default_nettype none
package sipf_pkg;

  localparam int NUM_REGS = 7;
  localparam int CFG_IDX_W = 3;

  // command codes
  localparam logic [3:0] CMD_PING         = 4'd0;
  localparam logic [3:0] CMD_LED          = 4'd1;
  localparam logic [3:0] CMD_GOAL         = 4'd2;
  localparam logic [3:0] CMD_ANGLE_LIMIT  = 4'd3;
  localparam logic [3:0] CMD_SPEED        = 4'd4;
  localparam logic [3:0] CMD_SET_ID       = 4'd5;
  localparam logic [3:0] CMD_MAX_TORQUE   = 4'd6;
  localparam logic [3:0] CMD_TORQUE_LIMIT = 4'd7;
  localparam logic [3:0] CMD_READ_POS     = 4'd8;

  // instruction codes
  localparam logic [7:0] INSTR_PING  = 8'h01;
  localparam logic [7:0] INSTR_READ  = 8'h02;
  localparam logic [7:0] INSTR_WRITE = 8'h03;

  localparam logic [7:0] HEADER_BYTE = 8'hFF;
  localparam logic [7:0] READ_LEN    = 8'h02;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LED          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ID           = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TORQUE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TORQUE_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENT_POS  = 3'd6;

  localparam logic [7:0] REG_RESET [NUM_REGS] = '{
    8'd25, 8'd30, 8'd32, 8'd3, 8'd14, 8'd34, 8'd36
  };

  // byte positions within a packet
  localparam logic [3:0] POS_HDR0  = 4'd0;
  localparam logic [3:0] POS_HDR1  = 4'd1;
  localparam logic [3:0] POS_ID    = 4'd2;
  localparam logic [3:0] POS_LEN   = 4'd3;
  localparam logic [3:0] POS_INSTR = 4'd4;
  localparam logic [3:0] POS_P0    = 4'd5;
  localparam logic [3:0] POS_P1    = 4'd6;
  localparam logic [3:0] POS_P2    = 4'd7;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] instr;
    logic [7:0] p0;
    logic [7:0] p1;
    logic [7:0] p2;
    logic [7:0] chk;
    logic [3:0] nbytes;
  } desc_t;

endpackage
`default_nettype wire

### design/sipf_front.sv
`default_nettype none
module sipf_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [sipf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data,
  input  wire logic                           in_push,
  input  wire logic [3:0]                     in_command,
  input  wire logic [7:0]                     in_servo_id,
  input  wire logic [15:0]                    in_value,
  input  wire logic [7:0]                     in_table_address,
  input  wire logic                           q_full,
  output logic                                q_push,
  output sipf_pkg::desc_t                     q_desc
);
  import sipf_pkg::*;

  logic [7:0] regs_r [NUM_REGS];
  logic       cmd_ok;
  logic [1:0] nparams;
  logic [7:0] instr, p0, p1, p2, len, lo, hi;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= REG_RESET[i];
    end else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
      regs_r[cfg_index] <= cfg_data;
    end
  end

  assign lo = in_value[7:0];
  assign hi = in_value[15:8];

  always_comb begin
    cmd_ok  = 1'b1;
    instr   = INSTR_WRITE;
    nparams = 2'd3;
    p0      = '0;
    p1      = lo;
    p2      = hi;
    unique case (in_command)
      CMD_PING: begin
        instr   = INSTR_PING;
        nparams = 2'd0;
        p1      = '0;
        p2      = '0;
      end
      CMD_LED: begin
        nparams = 2'd2;
        p0      = regs_r[REG_LED];
        p2      = '0;
      end
      CMD_GOAL:         p0 = regs_r[REG_GOAL];
      CMD_ANGLE_LIMIT:  p0 = in_table_address;
      CMD_SPEED:        p0 = regs_r[REG_SPEED];
      CMD_SET_ID: begin
        nparams = 2'd2;
        p0      = regs_r[REG_ID];
        p2      = '0;
      end
      CMD_MAX_TORQUE:   p0 = regs_r[REG_MAX_TORQUE];
      CMD_TORQUE_LIMIT: p0 = regs_r[REG_TORQUE_LIMIT];
      CMD_READ_POS: begin
        instr   = INSTR_READ;
        nparams = 2'd2;
        p0      = regs_r[REG_PRESENT_POS];
        p1      = READ_LEN;
        p2      = '0;
      end
      default: begin
        cmd_ok = 1'b0;
      end
    endcase
  end

  assign len = {6'd0, nparams} + 8'd2;

  always_comb begin
    q_desc.id     = in_servo_id;
    q_desc.len    = len;
    q_desc.instr  = instr;
    q_desc.p0     = p0;
    q_desc.p1     = p1;
    q_desc.p2     = p2;
    // unused parameters are zero so they drop out of the sum
    q_desc.chk    = ~(in_servo_id + len + instr + p0 + p1 + p2);
    q_desc.nbytes = {2'd0, nparams} + 4'd6;
  end

  assign q_push = in_push && !q_full && cmd_ok;

endmodule
`default_nettype wire

### design/sipf_queue.sv
`default_nettype none
module sipf_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire sipf_pkg::desc_t push_desc,
  input  wire logic            pop,
  output logic                 full,
  output logic                 empty,
  output sipf_pkg::desc_t      head
);
  import sipf_pkg::*;

  desc_t      mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

### design/sipf_back.sv
`default_nettype none
module sipf_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_empty,
  input  wire sipf_pkg::desc_t q_head,
  output logic                 q_pop,
  input  wire logic            out_pop,
  output logic                 out_empty,
  output logic [7:0]           out_tx_byte,
  output logic                 out_last_byte
);
  import sipf_pkg::*;

  logic [3:0] idx_r, idx_nxt;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic [7:0] cur_byte;
  logic       cur_last;
  logic       take;
  logic       drain;

  always_comb begin
    cur_last = (idx_r == q_head.nbytes - 4'd1);
    cur_byte = HEADER_BYTE;
    if (cur_last) begin
      cur_byte = q_head.chk;
    end else begin
      unique case (idx_r)
        POS_HDR0:  cur_byte = HEADER_BYTE;
        POS_HDR1:  cur_byte = HEADER_BYTE;
        POS_ID:    cur_byte = q_head.id;
        POS_LEN:   cur_byte = q_head.len;
        POS_INSTR: cur_byte = q_head.instr;
        POS_P0:    cur_byte = q_head.p0;
        POS_P1:    cur_byte = q_head.p1;
        POS_P2:    cur_byte = q_head.p2;
        default:   cur_byte = HEADER_BYTE;
      endcase
    end
  end

  assign drain   = out_pop && valid_r;
  // output register frees up in the same cycle it is popped
  assign take    = !q_empty && (!valid_r || drain);
  assign q_pop   = take && cur_last;
  assign idx_nxt = cur_last ? 4'd0 : idx_r + 4'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else if (take) begin
      idx_r   <= idx_nxt;
      valid_r <= 1'b1;
    end else if (drain) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= cur_byte;
      last_r <= cur_last;
    end
  end

  assign out_empty     = !valid_r;
  assign out_tx_byte   = byte_r;
  assign out_last_byte = last_r;

endmodule
`default_nettype wire

### design/servo_instruction_packet_framer.sv
// Throughput: one packet byte per cycle while out_pop is held; packets are 6, 8 or 9 bytes
// long. A command passes through the command queue and then the output byte register before
// its first byte reaches the result ports. A two-entry command queue lets the next command in while one is sent.
// Reset (synchronous, rst_n low): queue and output emptied, address registers
// return to their defaults; unused command codes are dropped without output.
`default_nettype none
module servo_instruction_packet_framer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [sipf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data,
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic [3:0]                     in_command,
  input  wire logic [7:0]                     in_servo_id,
  input  wire logic [15:0]                    in_value,
  input  wire logic [7:0]                     in_table_address,
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output logic [7:0]                          out_tx_byte,
  output logic                                out_last_byte
);
  import sipf_pkg::*;

  logic  q_full, q_empty, q_push, q_pop;
  desc_t q_desc, q_head;

  sipf_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_push          (in_push),
    .in_command       (in_command),
    .in_servo_id      (in_servo_id),
    .in_value         (in_value),
    .in_table_address (in_table_address),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_desc           (q_desc)
  );

  sipf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_desc),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  sipf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_tx_byte   (out_tx_byte),
    .out_last_byte (out_last_byte)
  );

  assign in_full = q_full;

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("framer not empty after reset");

  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !out_empty && out_last_byte)
    else $error("command retired without a checksum byte");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> !q_empty)
    else $error("accepted item missing from queue");

endmodule
`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps
module tb;
  import sipf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [7:0] tx;
    logic       last;
  } pkt_byte_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;
  logic                 in_push;
  logic                 in_full;
  logic [3:0]           in_command;
  logic [7:0]           in_servo_id;
  logic [15:0]          in_value;
  logic [7:0]           in_table_address;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic [7:0]           out_tx_byte;
  logic                 out_last_byte;

  logic [7:0] addr_model [NUM_REGS];
  logic [7:0] new_addr [NUM_REGS];
  pkt_byte_t  packet_bytes_due [$];
  pkt_byte_t  oldest_due;
  int         mismatch_count = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;

  servo_instruction_packet_framer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_command       (in_command),
    .in_servo_id      (in_servo_id),
    .in_value         (in_value),
    .in_table_address (in_table_address),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_tx_byte      (out_tx_byte),
    .out_last_byte    (out_last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Expected packet bytes for one command, appended to the queue of bytes due
  function automatic void frame_command(input logic [3:0] cmd, input logic [7:0] id,
                                        input logic [15:0] value, input logic [7:0] taddr);
    logic [7:0] instr;
    logic [7:0] p0;
    logic [7:0] p1;
    logic [7:0] p2;
    logic [7:0] len;
    logic [7:0] sum;
    int         np;
    instr = INSTR_WRITE;
    p0 = 8'h00;
    p1 = value[7:0];
    p2 = value[15:8];
    np = 3;
    case (cmd)
      CMD_PING: begin
        instr = INSTR_PING;
        p1 = 8'h00;
        p2 = 8'h00;
        np = 0;
      end
      CMD_LED: begin
        p0 = addr_model[REG_LED];
        p2 = 8'h00;
        np = 2;
      end
      CMD_GOAL:         p0 = addr_model[REG_GOAL];
      CMD_ANGLE_LIMIT:  p0 = taddr;
      CMD_SPEED:        p0 = addr_model[REG_SPEED];
      CMD_SET_ID: begin
        p0 = addr_model[REG_ID];
        p2 = 8'h00;
        np = 2;
      end
      CMD_MAX_TORQUE:   p0 = addr_model[REG_MAX_TORQUE];
      CMD_TORQUE_LIMIT: p0 = addr_model[REG_TORQUE_LIMIT];
      CMD_READ_POS: begin
        instr = INSTR_READ;
        p0 = addr_model[REG_PRESENT_POS];
        p1 = READ_LEN;
        p2 = 8'h00;
        np = 2;
      end
      default: return; // unused codes produce nothing
    endcase
    len = 8'(np + 2);
    sum = id + len + instr + p0 + p1 + p2;
    packet_bytes_due.push_back({HEADER_BYTE, 1'b0});
    packet_bytes_due.push_back({HEADER_BYTE, 1'b0});
    packet_bytes_due.push_back({id, 1'b0});
    packet_bytes_due.push_back({len, 1'b0});
    packet_bytes_due.push_back({instr, 1'b0});
    if (np > 0) packet_bytes_due.push_back({p0, 1'b0});
    if (np > 1) packet_bytes_due.push_back({p1, 1'b0});
    if (np > 2) packet_bytes_due.push_back({p2, 1'b0});
    packet_bytes_due.push_back({~sum, 1'b1});
  endfunction

  // byte checker; also decides the receiver stalls
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (packet_bytes_due.size() == 0) begin
        $error("unexpected packet byte tx_byte=%02h last_byte=%0b", out_tx_byte,
               out_last_byte);
        mismatch_count++;
      end else begin
        oldest_due = packet_bytes_due.pop_front();
        if (out_tx_byte !== oldest_due.tx) begin
          $error("tx_byte: expected %02h, got %02h", oldest_due.tx, out_tx_byte);
          mismatch_count++;
        end
        if (out_last_byte !== oldest_due.last) begin
          $error("last_byte: expected %0b, got %0b", oldest_due.last, out_last_byte);
          mismatch_count++;
        end
      end
    end
    out_pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic push_command(input logic [3:0] cmd, input logic [7:0] id,
                              input logic [15:0] value, input logic [7:0] taddr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push          <= 1'b1;
    in_command       <= cmd;
    in_servo_id      <= id;
    in_value         <= value;
    in_table_address <= taddr;
    do @(posedge clk); while (in_full);
    frame_command(cmd, id, value, taddr);
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    while (packet_bytes_due.size() != 0) @(posedge clk);
  endtask

  // unused codes may still be in flight when the queue runs dry
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_addresses();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= new_addr[i];
      do @(posedge clk); while (!cfg_ready);
      addr_model[i] = new_addr[i];
    end
    // out-of-range index must leave every register alone
    cfg_valid <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_data  <= 8'($urandom);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random(input int count);
    logic [3:0]  cmd;
    logic [7:0]  id;
    int          sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) cmd = 4'($urandom_range(15, 9));
      else cmd = 4'($urandom_range(8, 0));
      case ($urandom_range(7))
        0: id = 8'h00;
        1: id = 8'hFF;
        2: id = 8'hFE;
        default: id = 8'($urandom);
      endcase
      push_command(cmd, id, 16'($urandom), 8'($urandom));
      if (cmd <= CMD_READ_POS) sent++;
    end
  endtask

  task automatic test_directed();
    push_command(CMD_PING, 8'h00, 16'h0000, 8'h00);
    push_command(CMD_PING, 8'hFE, 16'hFFFF, 8'hFF);
    push_command(CMD_PING, 8'hFF, 16'hA5A5, 8'h5A);
    push_command(CMD_LED, 8'h01, 16'h0000, 8'hFF);
    push_command(CMD_LED, 8'hFF, 16'hFF01, 8'h00);
    push_command(CMD_GOAL, 8'h00, 16'hFFFF, 8'h00);
    push_command(CMD_GOAL, 8'h12, 16'h00FF, 8'hFF);
    push_command(CMD_ANGLE_LIMIT, 8'h03, 16'hFF00, 8'h00);
    push_command(CMD_ANGLE_LIMIT, 8'hFE, 16'h1234, 8'hFF);
    push_command(CMD_SPEED, 8'h7F, 16'h8000, 8'h00);
    push_command(CMD_SET_ID, 8'hFE, 16'hFFFF, 8'h00);
    push_command(CMD_SET_ID, 8'h00, 16'h0000, 8'h00);
    push_command(CMD_MAX_TORQUE, 8'h80, 16'h03FF, 8'h55);
    push_command(CMD_TORQUE_LIMIT, 8'hFF, 16'hFFFF, 8'hFF);
    push_command(CMD_READ_POS, 8'h01, 16'hFFFF, 8'hFF);
    push_command(CMD_READ_POS, 8'hFE, 16'h0000, 8'h00);
    push_command(4'd9, 8'h01, 16'h1111, 8'h22);
    push_command(4'd15, 8'hFF, 16'hFFFF, 8'hFF);
    push_command(CMD_PING, 8'h42, 16'h0000, 8'h00);
    push_command(4'd12, 8'h00, 16'h0000, 8'h00);
    push_command(CMD_GOAL, 8'hFF, 16'hFFFF, 8'hFF); // all-ones sum wraps the checksum
    settle();
  endtask

  task automatic test_address_extremes();
    foreach (new_addr[i]) new_addr[i] = 8'h00;
    apply_addresses();
    send_random(15);
    settle();
    foreach (new_addr[i]) new_addr[i] = 8'hFF;
    apply_addresses();
    send_random(15);
    settle();
  endtask

  task automatic test_random_phase(input int count);
    foreach (new_addr[i]) new_addr[i] = 8'($urandom);
    apply_addresses();
    send_random(count);
    settle();
  endtask

  task automatic test_hold_until_drained();
    send_random(12);
    wait_drained();
    send_random(12);
    settle();
  endtask

  initial begin
    rst_n            <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    in_push          <= 1'b0;
    in_command       <= '0;
    in_servo_id      <= '0;
    in_value         <= '0;
    in_table_address <= '0;
    foreach (addr_model[i]) addr_model[i] = REG_RESET[i];
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 25;
    recv_idle_pct = 61;
    test_directed();
    test_address_extremes();
    test_random_phase(100);

    send_idle_pct = 61;
    recv_idle_pct = 25;
    test_random_phase(100);
    test_hold_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_phase(100);

    settle();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
design/sipf_pkg.sv
design/sipf_front.sv
design/sipf_queue.sv
design/sipf_back.sv
design/servo_instruction_packet_framer.sv
tb/sv/tb.sv
